// File: src/wwmc_pkg.sv
// Shared types, constants and a helper function of the whole-word match counter.
package wwmc_pkg;

    localparam int QLEN_W      = 7;
    localparam int CNT_W       = 20;
    localparam int OFF_W       = 20;
    localparam int QWORDS      = 4;
    localparam int QUERY_STORE = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [2:0] REG_QUERY_0    = 3'd0;
    localparam logic [2:0] REG_QUERY_1    = 3'd1;
    localparam logic [2:0] REG_QUERY_2    = 3'd2;
    localparam logic [2:0] REG_QUERY_3    = 3'd3;
    localparam logic [2:0] REG_QUERY_LEN  = 3'd4;
    localparam logic [2:0] REG_CASE_INSEN = 3'd5;

    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [QLEN_W-1:0] qlen;
        logic              nocase;
    } wwmc_mode_t;

    function automatic logic is_word_char(input logic [7:0] b);
        logic r;
        r = ((b >= CHAR_0) && (b <= CHAR_9)) ||
            ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
            ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z));
        return r;
    endfunction

endpackage

// File: src/wwmc_cell.sv
// One cell of the history chain: holds a byte and compares the arriving byte.
module wwmc_cell
    import wwmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] byte_in,
    input  logic [7:0] query_byte,
    input  logic       active,
    output logic [7:0] byte_out,
    output logic       byte_eq,
    output logic       byte_word
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (clear) begin
            byte_next = '0;
        end else if (shift_en) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out  = byte_reg;
    assign byte_eq   = (byte_in == query_byte) || !active;
    assign byte_word = is_word_char(byte_in);

endmodule

// File: src/wwmc_cfg.sv
// Configuration registers with the APB port and the right-aligned query bytes.
module wwmc_cfg
    import wwmc_pkg::*;
#(
    parameter int MAX_QUERY_BYTES = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [5:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    output wwmc_mode_t                   mode,
    output logic [MAX_QUERY_BYTES*8-1:0] aligned_query
);

    logic [63:0] qword_reg [QWORDS];
    logic [5:0]  qlen_reg;
    logic        nocase_reg;
    logic        wr_en;
    logic [2:0]  reg_sel;
    logic [QLEN_W-1:0] qlen_eff;
    logic [QUERY_STORE*8-1:0] query_flat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QWORDS; i++) begin
                qword_reg[i] <= '0;
            end
            qlen_reg   <= 6'd1;
            nocase_reg <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_QUERY_0:    qword_reg[0] <= pwdata;
                REG_QUERY_1:    qword_reg[1] <= pwdata;
                REG_QUERY_2:    qword_reg[2] <= pwdata;
                REG_QUERY_3:    qword_reg[3] <= pwdata;
                REG_QUERY_LEN:  qlen_reg     <= pwdata[5:0];
                REG_CASE_INSEN: nocase_reg   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_QUERY_0:    prdata = qword_reg[0];
            REG_QUERY_1:    prdata = qword_reg[1];
            REG_QUERY_2:    prdata = qword_reg[2];
            REG_QUERY_3:    prdata = qword_reg[3];
            REG_QUERY_LEN:  prdata = {58'd0, qlen_reg};
            REG_CASE_INSEN: prdata = {63'd0, nocase_reg};
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        if ({1'b0, qlen_reg} > QLEN_W'(MAX_QUERY_BYTES)) begin
            qlen_eff = QLEN_W'(MAX_QUERY_BYTES);
        end else begin
            qlen_eff = {1'b0, qlen_reg};
        end
    end

    assign query_flat  = {qword_reg[3], qword_reg[2], qword_reg[1], qword_reg[0]};
    assign mode.qlen   = qlen_eff;
    assign mode.nocase = nocase_reg;

    // Cell k compares the byte k places back, so it faces query byte qlen-1-k.
    always_comb begin
        logic [QLEN_W-1:0] idx;
        aligned_query = '0;
        for (int k = 0; k < MAX_QUERY_BYTES; k++) begin
            idx = qlen_eff - QLEN_W'(k) - QLEN_W'(1);
            if ((QLEN_W'(k) < qlen_eff) && (idx < QLEN_W'(QUERY_STORE))) begin
                aligned_query[k*8 +: 8] = query_flat[idx[4:0]*8 +: 8];
            end
        end
    end

endmodule

// File: src/whole_word_match_counter_unit.sv
// Top level of the whole-word match counter: cell chain, hit tracking and result register.
//
//  Channel  Ports                      Direction  Carries
//  s_       s_valid s_ready s_op ...   in         one text byte or end of document
//  m_       m_valid m_ready m_hit...   out        count, first offset and flags
//  APB      psel penable pwrite ...    in         query bytes, length, case mode
//
// One item is taken in every cycle while the input is not stalled; the cell chain
// compares the whole window in the cycle the byte arrives.
// An end-of-document item registers its result in the output register.
// The input stalls only while that register holds a result that is not taken.
// Reset is synchronous; it and every end of document clear the chain and the tallies.
module whole_word_match_counter_unit
    import wwmc_pkg::*;
#(
    parameter int MAX_QUERY_BYTES = 32,
    parameter int POSITION_BITS   = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [7:0]        s_text_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CNT_W-1:0]  m_hit_count,
    output logic [OFF_W-1:0]  m_first_match_offset,
    output logic              m_any_match,
    output logic              m_too_long,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    localparam int PW   = POSITION_BITS;
    localparam int NC   = MAX_QUERY_BYTES;
    localparam int QI_W = $clog2(NC + 1);

    wwmc_mode_t          mode;
    logic [NC*8-1:0]     aligned_query;

    logic                in_fire;
    logic                text_fire;
    logic                eod_fire;
    logic [7:0]          byte_lc;
    logic                at_max;
    logic                shift_en;
    logic [7:0]          chain [NC+2];
    logic [NC:0]         cell_eq;
    logic [NC:0]         cell_word;
    logic [NC:0]         cell_active;
    logic                all_eq;
    logic [QI_W-1:0]     qlen_idx;
    logic                before_word;
    logic [PW-1:0]       pos_p1;
    logic [PW-1:0]       qlen_ext;
    logic [PW-1:0]       start_pos;
    logic                raw_hit;
    logic                new_pending;
    logic                resolve;

    logic [PW-1:0]       pos_reg,     pos_next;
    logic [PW-1:0]       nas_reg,     nas_next;
    logic                pend_reg,    pend_next;
    logic [PW-1:0]       pstart_reg,  pstart_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [PW-1:0]       first_reg,   first_next;
    logic                seen_reg,    seen_next;
    logic                ovf_reg,     ovf_next;
    logic [CNT_W-1:0]    tally_count;
    logic [PW-1:0]       tally_first;
    logic                tally_seen;
    logic [PW+OFF_W-1:0] first_wide;

    logic                ovalid_reg,  ovalid_next;
    logic [CNT_W-1:0]    ocount_reg;
    logic [OFF_W-1:0]    ooff_reg;
    logic                oany_reg;
    logic                olong_reg;

    wwmc_cfg #(
        .MAX_QUERY_BYTES (MAX_QUERY_BYTES)
    ) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .mode          (mode),
        .aligned_query (aligned_query)
    );

    assign s_ready   = !ovalid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign text_fire = in_fire && !s_op;
    assign eod_fire  = in_fire && s_op;

    always_comb begin
        byte_lc = s_text_byte;
        if (mode.nocase && (s_text_byte >= CHAR_UPPER_A) && (s_text_byte <= CHAR_UPPER_Z)) begin
            byte_lc = s_text_byte + CASE_OFFSET;
        end
    end

    assign at_max   = (pos_reg == {PW{1'b1}});
    assign shift_en = text_fire && !at_max;
    assign chain[0] = byte_lc;

    genvar k;
    generate
        for (k = 0; k <= NC; k++) begin : g_cell
            logic [7:0] qbyte;
            if (k < NC) begin : g_cmp
                assign qbyte          = aligned_query[k*8 +: 8];
                assign cell_active[k] = (QLEN_W'(k) < mode.qlen);
            end else begin : g_tail
                assign qbyte          = '0;
                assign cell_active[k] = 1'b0;
            end
            wwmc_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift_en   (shift_en),
                .clear      (eod_fire),
                .byte_in    (chain[k]),
                .query_byte (qbyte),
                .active     (cell_active[k]),
                .byte_out   (chain[k+1]),
                .byte_eq    (cell_eq[k]),
                .byte_word  (cell_word[k])
            );
        end
    endgenerate

    assign all_eq      = &cell_eq;
    assign qlen_idx    = mode.qlen[QI_W-1:0];
    assign before_word = cell_word[qlen_idx];

    assign pos_p1    = pos_reg + PW'(1);
    assign qlen_ext  = {{(PW-QLEN_W){1'b0}}, mode.qlen};
    assign start_pos = pos_p1 - qlen_ext;

    assign raw_hit = shift_en && (mode.qlen != '0) && (pos_p1 >= qlen_ext) &&
                     (start_pos >= nas_reg) && all_eq;
    assign new_pending = raw_hit && !before_word;
    assign resolve = pend_reg && (eod_fire || (text_fire && !is_word_char(byte_lc)));

    always_comb begin
        tally_count = count_reg;
        tally_first = first_reg;
        tally_seen  = seen_reg;
        if (resolve) begin
            if (!seen_reg) begin
                tally_seen  = 1'b1;
                tally_first = pstart_reg;
            end
            if (count_reg != CNT_MAX) begin
                tally_count = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        pos_next    = pos_reg;
        nas_next    = nas_reg;
        pend_next   = pend_reg;
        pstart_next = pstart_reg;
        count_next  = tally_count;
        first_next  = tally_first;
        seen_next   = tally_seen;
        ovf_next    = ovf_reg;
        if (eod_fire) begin
            pos_next    = '0;
            nas_next    = '0;
            pend_next   = 1'b0;
            pstart_next = '0;
            count_next  = '0;
            first_next  = '0;
            seen_next   = 1'b0;
            ovf_next    = 1'b0;
        end else if (text_fire) begin
            pend_next = new_pending;
            if (at_max) begin
                ovf_next = 1'b1;
            end else begin
                pos_next = pos_p1;
            end
            if (raw_hit) begin
                nas_next = pos_p1;
            end
            if (new_pending) begin
                pstart_next = start_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            nas_reg    <= '0;
            pend_reg   <= 1'b0;
            pstart_reg <= '0;
            count_reg  <= '0;
            first_reg  <= '0;
            seen_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            nas_reg    <= nas_next;
            pend_reg   <= pend_next;
            pstart_reg <= pstart_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            seen_reg   <= seen_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign first_wide  = {{OFF_W{1'b0}}, tally_first};
    assign ovalid_next = eod_fire || (ovalid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (eod_fire) begin
            ocount_reg <= tally_count;
            ooff_reg   <= tally_seen ? first_wide[OFF_W-1:0] : '0;
            oany_reg   <= tally_seen;
            olong_reg  <= ovf_reg;
        end
    end

    assign m_valid              = ovalid_reg;
    assign m_hit_count          = ocount_reg;
    assign m_first_match_offset = ooff_reg;
    assign m_any_match          = oany_reg;
    assign m_too_long           = olong_reg;

endmodule
